// ----- rtl/lkv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CAP_W  = 5;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;
    localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic hit;
        logic rd_en;
        logic wr_en;
    } lkv_access_t;

endpackage

`default_nettype wire

// ----- rtl/lkv_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lkv_req_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic signed [lkv_pkg::DATA_W-1:0] key;
    logic signed [lkv_pkg::DATA_W-1:0] write_value;

    modport source (output valid, output op, output key, output write_value, input ready);
    modport sink   (input valid, input op, input key, input write_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/lkv_resp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lkv_resp_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic signed [lkv_pkg::DATA_W-1:0] read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/lru_key_value_cache.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement.
// Requests arrive on req (valid/ready): op 0 is a get, op 1 is a put of
// write_value under key. Each request gives one response on resp
// (valid/ready): found tells whether the key was present, read_value carries
// the stored value on a get hit, all ones on a get miss and zero on a put.
// Keys, recency ranks and valid bits sit in a register array that is
// compared in parallel; values sit in a one-port-read synchronous RAM.
// The request is registered, then the tag compare and RAM access run in the
// lookup state; the RAM read data is registered and loaded in the fill state.
// No new request is taken while a lookup is in progress.
// A new request is taken in the cycle the previous response is loaded.
// If resp stalls, the response holds in its output register; one more request
// may be looked up, then req holds off until the register drains.
// cfg_we writes the capacity in use (values above MAX_ENTRIES act as
// MAX_ENTRIES); write it only while no request is outstanding.
// Reset clears all valid bits, empties the cache and sets capacity to 16.

module lru_key_value_cache #(
    parameter int unsigned MAX_ENTRIES = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [lkv_pkg::CAP_W-1:0]   cfg_wdata,
    lkv_req_if.sink                          req,
    lkv_resp_if.source                       resp
);

    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FILL
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [lkv_pkg::CAP_W-1:0]    cap_reg;
    logic                         op_reg;
    logic                         op_next;
    logic [lkv_pkg::DATA_W-1:0]   key_reg;
    logic [lkv_pkg::DATA_W-1:0]   key_next;
    logic [lkv_pkg::DATA_W-1:0]   wval_reg;
    logic [lkv_pkg::DATA_W-1:0]   wval_next;
    logic                         rsp_op_reg;
    logic                         rsp_op_next;
    logic                         rsp_found_reg;
    logic                         rsp_found_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_found_reg;
    logic                         out_found_next;
    logic [lkv_pkg::DATA_W-1:0]   out_data_reg;
    logic [lkv_pkg::DATA_W-1:0]   out_data_next;

    lkv_pkg::lkv_access_t         access;
    logic [IDX_W-1:0]             slot_idx;
    logic [lkv_pkg::DATA_W-1:0]   ram_rdata;
    logic                         in_lookup;
    logic                         resp_free;
    logic                         accept;

    assign in_lookup = (state_reg == ST_LOOKUP);
    assign resp_free = !out_valid_reg || resp.ready;
    assign req.ready = (state_reg == ST_IDLE) || ((state_reg == ST_FILL) && resp_free);
    assign accept    = req.valid && req.ready;

    lkv_tag_array #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_tags (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op_reg),
        .key    (key_reg),
        .cap    (cap_reg),
        .update (in_lookup),
        .access (access),
        .idx    (slot_idx)
    );

    lkv_ram #(
        .WIDTH (lkv_pkg::DATA_W),
        .DEPTH (MAX_ENTRIES)
    ) u_values (
        .clk   (clk),
        .we    (in_lookup && access.wr_en),
        .waddr (slot_idx),
        .wdata (wval_reg),
        .re    (in_lookup && access.rd_en),
        .raddr (slot_idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        wval_next      = wval_reg;
        rsp_op_next    = rsp_op_reg;
        rsp_found_next = rsp_found_reg;
        out_valid_next = out_valid_reg && !resp.ready;
        out_found_next = out_found_reg;
        out_data_next  = out_data_reg;

        if (accept)
        begin
            op_next   = req.op;
            key_next  = req.key;
            wval_next = req.write_value;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                rsp_op_next    = op_reg;
                rsp_found_next = access.hit;
                state_next     = ST_FILL;
            end
            ST_FILL:
            begin
                if (resp_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = rsp_found_reg;
                    if (rsp_op_reg == lkv_pkg::OP_PUT)
                    begin
                        out_data_next = lkv_pkg::PUT_VALUE;
                    end
                    else if (rsp_found_reg)
                    begin
                        out_data_next = ram_rdata;
                    end
                    else
                    begin
                        out_data_next = lkv_pkg::MISS_VALUE;
                    end
                    state_next = accept ? ST_LOOKUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= lkv_pkg::CAP_RESET;
            op_reg        <= lkv_pkg::OP_GET;
            key_reg       <= '0;
            wval_reg      <= '0;
            rsp_op_reg    <= lkv_pkg::OP_GET;
            rsp_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            op_reg        <= op_next;
            key_reg       <= key_next;
            wval_reg      <= wval_next;
            rsp_op_reg    <= rsp_op_next;
            rsp_found_reg <= rsp_found_next;
            out_valid_reg <= out_valid_next;
            out_found_reg <= out_found_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign resp.valid      = out_valid_reg;
    assign resp.found      = out_found_reg;
    assign resp.read_value = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/lkv_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lkv_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [ADDR_W-1:0]        waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [ADDR_W-1:0]        raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/lkv_tag_array.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lkv_tag_array #(
    parameter int unsigned MAX_ENTRIES = 16,
    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              op,
    input  wire logic [lkv_pkg::DATA_W-1:0]        key,
    input  wire logic [lkv_pkg::CAP_W-1:0]         cap,
    input  wire logic                              update,
    output lkv_pkg::lkv_access_t                   access,
    output logic      [IDX_W-1:0]                  idx
);

    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CW    = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

    logic [lkv_pkg::DATA_W-1:0] keys_reg   [MAX_ENTRIES];
    logic [lkv_pkg::DATA_W-1:0] keys_next  [MAX_ENTRIES];
    logic [IDX_W-1:0]           ranks_reg  [MAX_ENTRIES];
    logic [IDX_W-1:0]           ranks_next [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]     valid_reg;
    logic [MAX_ENTRIES-1:0]     valid_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;

    logic [MAX_ENTRIES-1:0] hit_vec;
    logic [MAX_ENTRIES-1:0] victim_vec;
    logic [MAX_ENTRIES-1:0] free_vec;
    logic [MAX_ENTRIES-1:0] kept_vec;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       hit_rank;
    logic [IDX_W-1:0]       slot_idx;
    logic [IDX_W-1:0]       oldest_rank;
    logic [CW-1:0]          cap_w;
    logic [CW-1:0]          cap_sat;
    logic [CW-1:0]          count_w;
    logic                   hit;
    logic                   full;
    logic                   evict;
    logic                   insert;

    always_comb
    begin
        hit_idx     = '0;
        hit_rank    = '0;
        slot_idx    = '0;
        oldest_rank = IDX_W'(count_reg - CNT_W'(1));
        cap_w       = CW'(cap);
        cap_sat     = (cap_w > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cap_w;
        count_w     = CW'(count_reg);
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            hit_vec[i]    = valid_reg[i] && (keys_reg[i] == key);
            victim_vec[i] = valid_reg[i] && (ranks_reg[i] == oldest_rank);
            if (hit_vec[i])
            begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | ranks_reg[i];
            end
        end
        hit    = |hit_vec;
        full   = (count_w >= cap_sat);
        evict  = (op == lkv_pkg::OP_PUT) && !hit && full && (count_reg != '0);
        insert = (op == lkv_pkg::OP_PUT) && !hit && (!full || (count_reg != '0));
        kept_vec = evict ? (valid_reg & ~victim_vec) : valid_reg;
        free_vec = ~kept_vec;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                slot_idx = IDX_W'(i);
            end
        end

        access.hit   = hit;
        access.rd_en = (op == lkv_pkg::OP_GET) && hit;
        access.wr_en = ((op == lkv_pkg::OP_PUT) && hit) || insert;
        idx          = hit ? hit_idx : slot_idx;
    end

    always_comb
    begin
        keys_next  = keys_reg;
        ranks_next = ranks_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        if (update)
        begin
            if (hit)
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (hit_vec[i])
                    begin
                        ranks_next[i] = '0;
                    end
                    else if (valid_reg[i] && (ranks_reg[i] < hit_rank))
                    begin
                        ranks_next[i] = ranks_reg[i] + IDX_W'(1);
                    end
                end
            end
            else if (insert)
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (kept_vec[i])
                    begin
                        ranks_next[i] = ranks_reg[i] + IDX_W'(1);
                    end
                end
                valid_next = kept_vec;
                valid_next[slot_idx] = 1'b1;
                keys_next[slot_idx]  = key;
                ranks_next[slot_idx] = '0;
                if (!evict)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        keys_reg  <= keys_next;
        ranks_reg <= ranks_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- tb/lru_cache_checker.sv -----
`timescale 1ns / 1ps

module lru_cache_checker #(
    parameter int unsigned SLOTS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata,
    lkv_req_if                        req,
    lkv_resp_if                       resp,
    output int                        fail_count,
    output int                        pending_count
);

    typedef struct packed {
        logic                       found;
        logic [lkv_pkg::DATA_W-1:0] value;
    } lookup_t;

    logic [lkv_pkg::DATA_W-1:0] slot_key [SLOTS];
    logic [lkv_pkg::DATA_W-1:0] slot_val [SLOTS];
    bit                         slot_used [SLOTS];
    int unsigned                slot_age [SLOTS];
    int unsigned                used_total;
    logic [lkv_pkg::CAP_W-1:0]  capacity;
    lookup_t                    lookup_q [$];
    lookup_t                    oldest;

    task automatic promote(input int s);
        int unsigned r;
        r = slot_age[s];
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_age[i] < r)
                slot_age[i]++;
        slot_age[s] = 0;
    endtask

    task automatic drop_oldest();
        int          victim;
        int unsigned best;
        victim = -1;
        best   = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && (victim < 0 || slot_age[i] >= best))
            begin
                victim = i;
                best   = slot_age[i];
            end
        if (victim >= 0)
        begin
            slot_used[victim] = 1'b0;
            if (used_total > 0)
                used_total--;
        end
    endtask

    task automatic store_new(input logic [lkv_pkg::DATA_W-1:0] k,
                             input logic [lkv_pkg::DATA_W-1:0] v);
        int s;
        s = -1;
        for (int i = 0; i < SLOTS; i++)
            if (!slot_used[i] && s < 0)
                s = i;
        if (s >= 0)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i])
                    slot_age[i]++;
            slot_key[s]  = k;
            slot_val[s]  = v;
            slot_age[s]  = 0;
            slot_used[s] = 1'b1;
            used_total++;
        end
    endtask

    task automatic predict_lookup(input logic op, input logic [lkv_pkg::DATA_W-1:0] k,
                                  input logic [lkv_pkg::DATA_W-1:0] v);
        int          hit;
        int unsigned limit;
        lookup_t     res;
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_key[i] == k && hit < 0)
                hit = i;
        limit = (capacity > SLOTS) ? SLOTS : capacity;
        if (op == lkv_pkg::OP_GET)
        begin
            if (hit >= 0)
            begin
                res = '{found: 1'b1, value: slot_val[hit]};
                promote(hit);
            end
            else
                res = '{found: 1'b0, value: lkv_pkg::MISS_VALUE};
        end
        else
        begin
            res = '{found: (hit >= 0), value: lkv_pkg::PUT_VALUE};
            if (hit >= 0)
            begin
                slot_val[hit] = v;
                promote(hit);
            end
            else if (used_total + 1 > limit)
            begin
                if (used_total > 0)
                begin
                    drop_oldest();
                    store_new(k, v);
                end
            end
            else
                store_new(k, v);
        end
        lookup_q.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_used[i] = 1'b0;
                slot_age[i]  = 0;
            end
            used_total = 0;
            capacity   = lkv_pkg::CAP_RESET;
            lookup_q.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_we)
                capacity = cfg_wdata;
            if (resp.valid && resp.ready)
            begin
                if (lookup_q.size() == 0)
                begin
                    $display("%0t: response with nothing outstanding, expected none, actual %0b %0d",
                             $time, resp.found, resp.read_value);
                    fail_count++;
                end
                else
                begin
                    oldest = lookup_q.pop_front();
                    if (resp.found !== oldest.found)
                    begin
                        $display("%0t: found mismatch, expected %0b actual %0b",
                                 $time, oldest.found, resp.found);
                        fail_count++;
                    end
                    if (resp.read_value !== oldest.value)
                    begin
                        $display("%0t: read_value mismatch, expected %0d actual %0d",
                                 $time, $signed(oldest.value), resp.read_value);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                predict_lookup(req.op, req.key, req.write_value);
            pending_count = lookup_q.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned SLOTS       = 16;
    localparam int          PHASES      = 10;
    localparam int          PHASE_ITEMS = 70;
    localparam int          STALL_LIMIT = 3000;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [lkv_pkg::CAP_W-1:0] cfg_wdata;
    int                        fail_count;
    int                        pending_count;
    int                        idle_cycles;
    int                        long_stall_len;
    bit                        idle_on;
    int                        n_gets;
    int                        n_puts;

    lkv_req_if  req_ch ();
    lkv_resp_if resp_ch ();

    lru_key_value_cache #(
        .MAX_ENTRIES (SLOTS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .resp      (resp_ch)
    );

    lru_cache_checker #(
        .SLOTS (SLOTS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req           (req_ch),
        .resp          (resp_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (req_ch.valid && req_ch.ready)
            || (resp_ch.valid && resp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int hold;
        resp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_stall_len > 0)
            begin
                hold = long_stall_len;
                long_stall_len = 0;
                resp_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
                resp_ch.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                resp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                resp_ch.ready <= 1'b1;
            end
            else
                resp_ch.ready <= 1'b1;
        end
    end

    task automatic send_request(input logic op, input logic [lkv_pkg::DATA_W-1:0] k,
                                input logic [lkv_pkg::DATA_W-1:0] v);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.key         <= k;
        req_ch.write_value <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (op == lkv_pkg::OP_GET)
            n_gets++;
        else
            n_puts++;
    endtask

    task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] c);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [lkv_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [lkv_pkg::CAP_W-1:0]  caps [PHASES];
        logic [lkv_pkg::DATA_W-1:0] pool [20];
        logic [lkv_pkg::DATA_W-1:0] k;
        logic                       op;
        int                         pool_n;
        int unsigned                eff_cap;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.op          <= lkv_pkg::OP_GET;
        req_ch.key         <= '0;
        req_ch.write_value <= '0;
        long_stall_len = 0;
        idle_on        = 1'b1;
        n_gets         = 0;
        n_puts         = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero capacity on an empty cache stores nothing
        write_capacity(5'd0);
        send_request(lkv_pkg::OP_PUT, 32'd5, 32'd123);
        send_request(lkv_pkg::OP_GET, 32'd5, '0);

        write_capacity(5'd16);
        send_request(lkv_pkg::OP_GET, 32'd0, 32'hFFFF_FFFF);
        send_request(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(lkv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(lkv_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(lkv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(lkv_pkg::OP_GET, 32'h8000_0000, '0);
        send_request(lkv_pkg::OP_GET, 32'h7FFF_FFFF, '0);
        send_request(lkv_pkg::OP_PUT, 32'h0000_0000, 32'h5555_5555);
        send_request(lkv_pkg::OP_GET, 32'h0000_0000, '0);
        send_request(lkv_pkg::OP_GET, 32'hFFFF_FFFF, '0);
        send_request(lkv_pkg::OP_GET, 32'h0000_0001, '0);

        // shrink below the current fill: each insert drops only the oldest
        write_capacity(5'd2);
        send_request(lkv_pkg::OP_PUT, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        send_request(lkv_pkg::OP_GET, 32'h7FFF_FFFF, '0);
        send_request(lkv_pkg::OP_GET, 32'h8000_0000, '0);
        send_request(lkv_pkg::OP_GET, 32'h0000_0000, '0);
        send_request(lkv_pkg::OP_GET, 32'hFFFF_FFFF, '0);
        send_request(lkv_pkg::OP_PUT, 32'h5555_5555, 32'h1234_5678);
        send_request(lkv_pkg::OP_GET, 32'hAAAA_AAAA, '0);
        send_request(lkv_pkg::OP_PUT, 32'hAAAA_AAAA, 32'h0F0F_0F0F);

        caps = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd17, 5'd0, 5'd8, 5'd2, 5'd3, 5'd16};
        caps[PHASES-1] = 5'($urandom_range(0, 31));
        for (int i = 0; i < 20; i++)
            pool[i] = $urandom;
        pool[0] = 32'h7FFF_FFFF;
        pool[1] = 32'h8000_0000;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_capacity(caps[ph]);
            idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            eff_cap = (caps[ph] > SLOTS) ? SLOTS : caps[ph];
            pool_n  = eff_cap + 3;
            for (int i = 4; i < 20; i++)
                pool[i] = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 3 && n == 10)
                    long_stall_len = 100;
                op = $urandom_range(0, 1) ? lkv_pkg::OP_PUT : lkv_pkg::OP_GET;
                if ($urandom_range(0, 6) == 0)
                    k = $urandom;
                else
                    k = pool[$urandom_range(0, pool_n - 1)];
                send_request(op, k, pick_value());
            end
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (8) @(posedge clk);
        $display("Ran %0d gets and %0d puts over %0d capacity settings,", n_gets, n_puts,
                 PHASES + 3);
        $display("including zero, one, full and saturating capacity and a long response stall.");
        if (fail_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
